[rtl/mpwm_pkg.sv]
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants for the masked pattern window match block.
// ----------------------------------------------------------------------------
package mpwm_pkg;

    // Default and largest pattern length in bytes
    localparam int MAX_LEN_DEF = 8;
    localparam int PAT_W       = 64;
    localparam int LEN_W       = 4;
    localparam int OFS_W       = 16;
    localparam int CFG_IDX_W   = 3;

    // File position counter, saturating
    localparam int              POS_W   = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 3'd0,
        REG_PATTERN_MASK   = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_WINDOW_START   = 3'd3,
        REG_WINDOW_END     = 3'd4
    } cfg_reg_e;

    // Input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic matched;
        logic decided;
    } out_item_t;

    // Configuration register set
    typedef struct packed {
        logic [PAT_W-1:0] pattern_bytes;
        logic [PAT_W-1:0] pattern_mask;
        logic [LEN_W-1:0] pattern_length;
        logic [OFS_W-1:0] window_start;
        logic [OFS_W-1:0] window_end;
    } cfg_t;

endpackage

[rtl/masked_pattern_window_match.sv]
// ----------------------------------------------------------------------------
// masked_pattern_window_match
// Streams a file byte by byte and reports whether a masked pattern of up to
// MAX_LEN bytes starts at any offset in [window_start, window_end].
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while out_ready stays high and
// returns one result per byte, registered in the cycle after the byte is
// accepted. The whole update (window shift, masked compare of all
// candidate lengths, offset checks) is combinational. A new byte is
// accepted in the same cycle that the previous result is taken, so bytes
// stream back to back while out_ready stays high; a result held by
// out_ready low stalls the input until it is taken. Mark offset zero of
// each file with first_byte; write the configuration only while the block
// is idle. A changed register takes effect from the next byte on.
module masked_pattern_window_match
    import mpwm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]     cfg_data
);

    cfg_t      cfg;
    out_item_t result;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      in_accept;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    mpwm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Accept a request whenever the result slot is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    mpwm_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    // Hold the result until taken
    always_comb
    begin
        priority if (in_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A found match is always final
    a_match_decided: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !out_reg.matched || out_reg.decided)
        else $error("match reported as not final");

    // Every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("result missing after accepted request");

    // An undelivered result blocks no more than one slot
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_ready)
        else $error("request accepted over a pending result");

endmodule

[rtl/mpwm_cfg.sv]
// ----------------------------------------------------------------------------
// mpwm_cfg
// Configuration register file: pattern, mask, length, window start and window end.
// ----------------------------------------------------------------------------
module mpwm_cfg
    import mpwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PAT_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write request; unknown indexes leave the registers alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_e'(wr_index))
                REG_PATTERN_BYTES:  cfg_next.pattern_bytes  = wr_data;
                REG_PATTERN_MASK:   cfg_next.pattern_mask   = wr_data;
                REG_PATTERN_LENGTH: cfg_next.pattern_length = wr_data[LEN_W-1:0];
                REG_WINDOW_START:   cfg_next.window_start   = wr_data[OFS_W-1:0];
                REG_WINDOW_END:     cfg_next.window_end     = wr_data[OFS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes  <= '0;
            cfg_reg.pattern_mask   <= '1;
            cfg_reg.pattern_length <= '0;
            cfg_reg.window_start   <= '0;
            cfg_reg.window_end     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/mpwm_core.sv]
// ----------------------------------------------------------------------------
// mpwm_core
// Byte window, position counter and sticky match flag, with a parallel
// masked compare of every candidate pattern length, all combinational.
// ----------------------------------------------------------------------------
module mpwm_core
    import mpwm_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [7:0]       win_reg  [MAX_LEN];
    logic [7:0]       win_next [MAX_LEN];
    logic [7:0]       win_base [MAX_LEN];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             match_seen_reg;
    logic             match_seen_next;

    logic [POS_W-1:0] pos_base;
    logic             match_base;
    logic [POS_W:0]   pos_inc;
    logic [POS_W:0]   len_ext;
    logic [POS_W:0]   start_ofs;
    logic [MAX_LEN:1] len_eq;
    logic             sel_eq;
    logic             len_ok;
    logic             reach;
    logic             in_range;
    logic             past_end;

    // Drop the old file state when a new file begins
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            win_base[i] = item.first_byte ? 8'h00 : win_reg[i];
        end
        pos_base   = item.first_byte ? '0 : pos_reg;
        match_base = item.first_byte ? 1'b0 : match_seen_reg;
    end

    // Shift the new byte into the window, newest at entry 0
    always_comb
    begin
        win_next[0] = item.data_byte;
        for (int i = 1; i < MAX_LEN; i++)
        begin
            win_next[i] = win_base[i-1];
        end
    end

    // Compare the window against the pattern for each possible length
    always_comb
    begin
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            len_eq[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (((cfg.pattern_bytes[8*k +: 8] ^ win_next[l-1-k])
                     & cfg.pattern_mask[8*k +: 8]) != 8'h00)
                begin
                    len_eq[l] = 1'b0;
                end
            end
        end
    end

    // Pick the compare for the configured length
    always_comb
    begin
        sel_eq = 1'b0;
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            if (cfg.pattern_length == LEN_W'(l))
            begin
                sel_eq = len_eq[l];
            end
        end
    end

    // Check the start offset against the window and decide
    always_comb
    begin
        len_ok    = (cfg.pattern_length != '0) &&
                    (cfg.pattern_length <= LEN_W'(MAX_LEN));
        pos_inc   = {1'b0, pos_base} + (POS_W+1)'(1);
        len_ext   = (POS_W+1)'(cfg.pattern_length);
        reach     = pos_inc >= len_ext;
        start_ofs = pos_inc - len_ext;
        in_range  = (start_ofs >= (POS_W+1)'(cfg.window_start)) &&
                    (start_ofs <= (POS_W+1)'(cfg.window_end));
        past_end  = pos_inc >= ((POS_W+1)'(cfg.window_end) + len_ext);

        match_seen_next = match_base ||
                          (len_ok && reach && in_range && sel_eq);
        pos_next        = (pos_base < POS_MAX) ? pos_inc[POS_W-1:0] : pos_base;

        result.matched  = match_seen_next;
        result.decided  = match_seen_next || !len_ok || past_end;
    end

    // Advance the file state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            pos_reg        <= '0;
            match_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            win_reg        <= win_next;
            pos_reg        <= pos_next;
            match_seen_reg <= match_seen_next;
        end
    end

    // A new file restarts the position at one byte in
    a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.first_byte |=> pos_reg == POS_W'(1))
        else $error("position not restarted by first byte");

    // The match flag is sticky within a file
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !item.first_byte && match_seen_reg |=> match_seen_reg)
        else $error("match flag dropped within a file");

    // State holds without a request
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pos_reg) && $stable(match_seen_reg))
        else $error("state changed without a request");

endmodule
